// ===== hw/rtl/indexed_min_heap_top_macros.svh =====
// Assertion macros for the indexed min-heap RTL.
// Needs signals clk and rst_n in the scope of each use.
`ifndef INDEXED_MIN_HEAP_TOP_MACROS_SVH
`define INDEXED_MIN_HEAP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IMH_ASSERT(lbl, cond, msg)
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/imh_pkg.sv =====
// Shared types, constants and the key compare for the indexed min-heap.
// No dependencies.
package imh_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KID_W    = POS_W + 2;
  localparam int SLOT_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STS_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_PEEK     = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_DEC_REJ  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_INS_RD, ST_UP_CHK, ST_UP_PAR, ST_UP_CMP,
    ST_UP_SW2, ST_DEC_CHK, ST_PEEK_RD, ST_PEEK_KEY, ST_EXT_RD0, ST_EXT_RD1,
    ST_EXT_SW1, ST_EXT_SW2, ST_DN_R, ST_DN_RD_R, ST_DN_CMP_R, ST_DN_L,
    ST_DN_RD_L, ST_DN_CMP_L, ST_DN_DEC, ST_DN_SW2, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_DISPATCH, OP_INS_RD, OP_UP_CHK, OP_UP_PAR, OP_UP_CMP,
    OP_UP_SW2, OP_DEC_CHK, OP_PEEK_RD, OP_PEEK_KEY, OP_EXT_RD0, OP_EXT_RD1,
    OP_EXT_SW1, OP_EXT_SW2, OP_DN_R, OP_DN_RD_R, OP_DN_CMP_R, OP_DN_L,
    OP_DN_RD_L, OP_DN_CMP_L, OP_DN_DEC, OP_DN_SW2, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_valid;
    logic full;
    logic empty;
    logic p_zero;
    logic up_stop;
    logic dec_bad;
    logic r_in;
    logic l_in;
    logic best_self;
    logic clr_last;
    logic out_free;
  } sts_t;

  // Less-or-equal on keys; signed order flips the sign bits first.
  function automatic logic key_leq(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b,
                                   logic sgn);
    logic [KEY_BITS-1:0] fa;
    logic [KEY_BITS-1:0] fb;
    fa = a ^ {sgn, {(KEY_BITS-1){1'b0}}};
    fb = b ^ {sgn, {(KEY_BITS-1){1'b0}}};
    return fa <= fb;
  endfunction

endpackage

// ===== hw/rtl/imh_stream_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on imh_pkg.
interface imh_in_if;
  logic                        valid;
  logic                        ready;
  logic [imh_pkg::CMD_W-1:0]   command;
  logic [imh_pkg::KEY_BITS-1:0] key;
  logic [imh_pkg::SLOT_W-1:0]  slot;
  modport source (output valid, command, key, slot, input ready);
  modport sink (input valid, command, key, slot, output ready);
endinterface

interface imh_out_if;
  logic                        valid;
  logic                        ready;
  logic [imh_pkg::STS_W-1:0]   status;
  logic [imh_pkg::KEY_BITS-1:0] result_key;
  logic [imh_pkg::SLOT_W-1:0]  result_slot;
  logic [imh_pkg::CNT_W-1:0]   occupancy;
  modport source (output valid, status, result_key, result_slot, occupancy, input ready);
  modport sink (input valid, status, result_key, result_slot, occupancy, output ready);
endinterface

// ===== hw/rtl/indexed_min_heap_top.sv =====
// Top level of the indexed min-heap: sequencer plus datapath.
// Depends on imh_pkg, imh_stream_if, imh_ctrl, imh_dp.
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | command, key, slot
//  out_ch   | out | valid/ready      | status, result_key, result_slot, occupancy
//  cfg      | in  | cfg_we           | cfg_wdata (signed_compare)
//
// One command at a time. Peek, full or empty rejects and rejected decreases
// finish without a walk; insert and decrease walk the entry up level by level
// until it stops below its parent or reaches the root; extract moves the last
// entry to the root and walks it down, checking the right child, then the left.
// The walk over heap levels goes through three single-read memories.
// After reset a pass over every position loads identity maps; in_ch.ready stays low.
// A result waiting on out_ch holds only the final step of the next command.
module indexed_min_heap_top (
  input  logic      clk,
  input  logic      rst_n,
  imh_in_if.sink    in_ch,
  imh_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  imh_pkg::ctl_t ctl;
  imh_pkg::sts_t sts;

  imh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .ctl(ctl));

  imh_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .ctl(ctl), .sts(sts));
endmodule

// ===== hw/rtl/imh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// ===== hw/rtl/imh_ctrl.sv =====
// Sequencer for the indexed min-heap: walks insert, extract, decrease and peek.
// Depends on imh_pkg; drives the datapath through ctl_t, reads sts_t.
module imh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  imh_pkg::sts_t   sts,
  output imh_pkg::ctl_t   ctl
);
  imh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imh_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imh_pkg::ST_CLEAR:    if (sts.clr_last) state_nxt = imh_pkg::ST_IDLE;
      imh_pkg::ST_IDLE:     if (sts.in_valid) state_nxt = imh_pkg::ST_DISPATCH;
      imh_pkg::ST_DISPATCH: begin
        case (sts.cmd)
          imh_pkg::CMD_INSERT:
            state_nxt = sts.full ? imh_pkg::ST_DONE : imh_pkg::ST_INS_RD;
          imh_pkg::CMD_EXTRACT:
            state_nxt = sts.empty ? imh_pkg::ST_DONE : imh_pkg::ST_EXT_RD0;
          imh_pkg::CMD_DECREASE:
            state_nxt = imh_pkg::ST_DEC_CHK;
          default:
            state_nxt = sts.empty ? imh_pkg::ST_DONE : imh_pkg::ST_PEEK_RD;
        endcase
      end
      imh_pkg::ST_INS_RD:   state_nxt = imh_pkg::ST_UP_CHK;
      imh_pkg::ST_UP_CHK:
        state_nxt = sts.p_zero ? imh_pkg::ST_DONE : imh_pkg::ST_UP_PAR;
      imh_pkg::ST_UP_PAR:   state_nxt = imh_pkg::ST_UP_CMP;
      imh_pkg::ST_UP_CMP:
        state_nxt = sts.up_stop ? imh_pkg::ST_DONE : imh_pkg::ST_UP_SW2;
      imh_pkg::ST_UP_SW2:   state_nxt = imh_pkg::ST_UP_CHK;
      imh_pkg::ST_DEC_CHK:
        state_nxt = sts.dec_bad ? imh_pkg::ST_DONE : imh_pkg::ST_UP_CHK;
      imh_pkg::ST_PEEK_RD:  state_nxt = imh_pkg::ST_PEEK_KEY;
      imh_pkg::ST_PEEK_KEY: state_nxt = imh_pkg::ST_DONE;
      imh_pkg::ST_EXT_RD0:  state_nxt = imh_pkg::ST_EXT_RD1;
      imh_pkg::ST_EXT_RD1:  state_nxt = imh_pkg::ST_EXT_SW1;
      imh_pkg::ST_EXT_SW1:  state_nxt = imh_pkg::ST_EXT_SW2;
      imh_pkg::ST_EXT_SW2:  state_nxt = imh_pkg::ST_DN_R;
      imh_pkg::ST_DN_R:
        state_nxt = sts.r_in ? imh_pkg::ST_DN_RD_R : imh_pkg::ST_DN_L;
      imh_pkg::ST_DN_RD_R:  state_nxt = imh_pkg::ST_DN_CMP_R;
      imh_pkg::ST_DN_CMP_R: state_nxt = imh_pkg::ST_DN_L;
      imh_pkg::ST_DN_L:
        state_nxt = sts.l_in ? imh_pkg::ST_DN_RD_L : imh_pkg::ST_DN_DEC;
      imh_pkg::ST_DN_RD_L:  state_nxt = imh_pkg::ST_DN_CMP_L;
      imh_pkg::ST_DN_CMP_L: state_nxt = imh_pkg::ST_DN_DEC;
      imh_pkg::ST_DN_DEC:
        state_nxt = sts.best_self ? imh_pkg::ST_DONE : imh_pkg::ST_DN_SW2;
      imh_pkg::ST_DN_SW2:   state_nxt = imh_pkg::ST_DN_R;
      imh_pkg::ST_DONE:     if (sts.out_free) state_nxt = imh_pkg::ST_IDLE;
      default:              state_nxt = imh_pkg::ST_IDLE;
    endcase
  end

  // outputs: one datapath step per state
  always_comb begin
    ctl.op = imh_pkg::OP_IDLE;
    case (state_r)
      imh_pkg::ST_CLEAR:    ctl.op = imh_pkg::OP_CLEAR;
      imh_pkg::ST_IDLE:     ctl.op = imh_pkg::OP_IDLE;
      imh_pkg::ST_DISPATCH: ctl.op = imh_pkg::OP_DISPATCH;
      imh_pkg::ST_INS_RD:   ctl.op = imh_pkg::OP_INS_RD;
      imh_pkg::ST_UP_CHK:   ctl.op = imh_pkg::OP_UP_CHK;
      imh_pkg::ST_UP_PAR:   ctl.op = imh_pkg::OP_UP_PAR;
      imh_pkg::ST_UP_CMP:   ctl.op = imh_pkg::OP_UP_CMP;
      imh_pkg::ST_UP_SW2:   ctl.op = imh_pkg::OP_UP_SW2;
      imh_pkg::ST_DEC_CHK:  ctl.op = imh_pkg::OP_DEC_CHK;
      imh_pkg::ST_PEEK_RD:  ctl.op = imh_pkg::OP_PEEK_RD;
      imh_pkg::ST_PEEK_KEY: ctl.op = imh_pkg::OP_PEEK_KEY;
      imh_pkg::ST_EXT_RD0:  ctl.op = imh_pkg::OP_EXT_RD0;
      imh_pkg::ST_EXT_RD1:  ctl.op = imh_pkg::OP_EXT_RD1;
      imh_pkg::ST_EXT_SW1:  ctl.op = imh_pkg::OP_EXT_SW1;
      imh_pkg::ST_EXT_SW2:  ctl.op = imh_pkg::OP_EXT_SW2;
      imh_pkg::ST_DN_R:     ctl.op = imh_pkg::OP_DN_R;
      imh_pkg::ST_DN_RD_R:  ctl.op = imh_pkg::OP_DN_RD_R;
      imh_pkg::ST_DN_CMP_R: ctl.op = imh_pkg::OP_DN_CMP_R;
      imh_pkg::ST_DN_L:     ctl.op = imh_pkg::OP_DN_L;
      imh_pkg::ST_DN_RD_L:  ctl.op = imh_pkg::OP_DN_RD_L;
      imh_pkg::ST_DN_CMP_L: ctl.op = imh_pkg::OP_DN_CMP_L;
      imh_pkg::ST_DN_DEC:   ctl.op = imh_pkg::OP_DN_DEC;
      imh_pkg::ST_DN_SW2:   ctl.op = imh_pkg::OP_DN_SW2;
      imh_pkg::ST_DONE:     ctl.op = imh_pkg::OP_DONE;
      default:              ctl.op = imh_pkg::OP_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/imh_dp.sv =====
// Datapath of the indexed min-heap: key store, both slot/position maps,
// working registers and the result register. Depends on imh_pkg, imh_ram.
`include "indexed_min_heap_top_macros.svh"
module imh_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  imh_in_if.sink                      in_ch,
  imh_out_if.source                   out_ch,
  input  imh_pkg::ctl_t               ctl,
  output imh_pkg::sts_t               sts
);
  localparam int PW = imh_pkg::POS_W;
  localparam int CW = imh_pkg::CNT_W;
  localparam int KW = imh_pkg::KEY_BITS;
  localparam int DW = imh_pkg::KID_W;

  // memories
  logic          key_we, pos_we, sap_we;
  logic [PW-1:0] key_wa, key_ra, pos_wa, pos_ra, sap_wa, sap_ra;
  logic [KW-1:0] key_wd, key_rd;
  logic [PW-1:0] pos_wd, pos_rd, sap_wd, sap_rd;

  imh_ram #(.WIDTH(KW), .DEPTH(imh_pkg::CAPACITY)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata_r(key_rd));
  imh_ram #(.WIDTH(PW), .DEPTH(imh_pkg::CAPACITY)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata_r(pos_rd));
  imh_ram #(.WIDTH(PW), .DEPTH(imh_pkg::CAPACITY)) u_sap (
    .clk(clk), .we(sap_we), .waddr(sap_wa), .wdata(sap_wd), .raddr(sap_ra), .rdata_r(sap_rd));

  // working registers
  imh_pkg::cmd_t    cmd_r;
  imh_pkg::status_t status_r;
  logic [KW-1:0]    in_key_r, largest_r, k_r, ok_r, res_key_r;
  logic [PW-1:0]    in_slot_r, s_r, p_r, o_r, op_r, c_r, res_slot_r, clr_r;
  logic [CW-1:0]    cnt_r;
  logic             sgn_r;
  logic             out_valid_r;
  logic [imh_pkg::STS_W-1:0]  out_status_r;
  logic [KW-1:0]    out_key_r;
  logic [PW-1:0]    out_slot_r;
  logic [CW-1:0]    out_cnt_r;

  logic [PW-1:0] parent;
  logic [DW-1:0] rkid, lkid, cnt_x;
  logic [CW-1:0] cnt_m1;
  logic          out_free;

  assign parent   = (p_r - PW'(1)) >> 1;
  assign rkid     = {1'b0, p_r, 1'b0} + DW'(2);
  assign lkid     = {1'b0, p_r, 1'b1};
  assign cnt_x    = DW'(cnt_r);
  assign cnt_m1   = cnt_r - CW'(1);
  assign out_free = !out_valid_r || out_ch.ready;

  // status toward the sequencer
  always_comb begin
    sts.cmd       = imh_pkg::cmd_t'(cmd_r);
    sts.in_valid  = in_ch.valid;
    sts.full      = cnt_r >= CW'(imh_pkg::CAPACITY);
    sts.empty     = cnt_r == '0;
    sts.p_zero    = p_r == '0;
    sts.up_stop   = imh_pkg::key_leq(key_rd, k_r, sgn_r);
    sts.dec_bad   = ({1'b0, pos_rd} >= cnt_r) || !imh_pkg::key_leq(in_key_r, key_rd, sgn_r);
    sts.r_in      = rkid < cnt_x;
    sts.l_in      = lkid < cnt_x;
    sts.best_self = o_r == s_r;
    sts.clr_last  = clr_r == PW'(imh_pkg::CAPACITY - 1);
    sts.out_free  = out_free;
  end

  // memory port selection per step
  always_comb begin
    key_we = 1'b0; key_wa = s_r;  key_wd = k_r; key_ra = o_r;
    pos_we = 1'b0; pos_wa = s_r;  pos_wd = op_r; pos_ra = in_slot_r;
    sap_we = 1'b0; sap_wa = op_r; sap_wd = s_r; sap_ra = '0;
    case (ctl.op)
      imh_pkg::OP_CLEAR: begin
        pos_we = 1'b1; pos_wa = clr_r; pos_wd = clr_r;
        sap_we = 1'b1; sap_wa = clr_r; sap_wd = clr_r;
      end
      imh_pkg::OP_DISPATCH: begin
        sap_ra = (cmd_r == imh_pkg::CMD_INSERT) ? cnt_r[PW-1:0] : '0;
        pos_ra = in_slot_r;
        key_ra = in_slot_r;
      end
      imh_pkg::OP_INS_RD: begin
        key_we = 1'b1; key_wa = sap_rd; key_wd = in_key_r;
      end
      imh_pkg::OP_UP_CHK:  sap_ra = parent;
      imh_pkg::OP_UP_PAR:  key_ra = sap_rd;
      imh_pkg::OP_UP_CMP: begin
        if (!sts.up_stop) begin
          pos_we = 1'b1; pos_wa = s_r; pos_wd = op_r;
          sap_we = 1'b1; sap_wa = op_r; sap_wd = s_r;
        end
      end
      imh_pkg::OP_UP_SW2: begin
        pos_we = 1'b1; pos_wa = o_r; pos_wd = p_r;
        sap_we = 1'b1; sap_wa = p_r; sap_wd = o_r;
      end
      imh_pkg::OP_DEC_CHK: begin
        if (!sts.dec_bad) begin
          key_we = 1'b1; key_wa = in_slot_r; key_wd = in_key_r;
        end
      end
      imh_pkg::OP_PEEK_RD: key_ra = sap_rd;
      imh_pkg::OP_EXT_RD0: begin
        sap_ra = cnt_m1[PW-1:0];
        key_ra = sap_rd;
      end
      imh_pkg::OP_EXT_RD1: key_ra = sap_rd;
      imh_pkg::OP_EXT_SW1: begin
        pos_we = 1'b1; pos_wa = o_r; pos_wd = cnt_m1[PW-1:0];
        sap_we = 1'b1; sap_wa = '0;  sap_wd = s_r;
      end
      imh_pkg::OP_EXT_SW2: begin
        pos_we = 1'b1; pos_wa = s_r; pos_wd = '0;
        sap_we = 1'b1; sap_wa = cnt_m1[PW-1:0]; sap_wd = o_r;
      end
      imh_pkg::OP_DN_R:     sap_ra = rkid[PW-1:0];
      imh_pkg::OP_DN_RD_R:  key_ra = sap_rd;
      imh_pkg::OP_DN_L:     sap_ra = lkid[PW-1:0];
      imh_pkg::OP_DN_RD_L:  key_ra = sap_rd;
      imh_pkg::OP_DN_DEC: begin
        if (!sts.best_self) begin
          pos_we = 1'b1; pos_wa = o_r; pos_wd = p_r;
          sap_we = 1'b1; sap_wa = p_r; sap_wd = o_r;
        end
      end
      imh_pkg::OP_DN_SW2: begin
        pos_we = 1'b1; pos_wa = s_r; pos_wd = op_r;
        sap_we = 1'b1; sap_wa = op_r; sap_wd = s_r;
      end
      default: ;
    endcase
  end

  // control registers: count, clear index, config, largest key, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      clr_r       <= '0;
      sgn_r       <= 1'b0;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) sgn_r <= cfg_wdata;
      if (ctl.op == imh_pkg::OP_CLEAR) clr_r <= clr_r + PW'(1);
      if (ctl.op == imh_pkg::OP_INS_RD) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == '0 || !imh_pkg::key_leq(in_key_r, largest_r, sgn_r)) begin
          largest_r <= in_key_r;
        end
      end
      if (ctl.op == imh_pkg::OP_EXT_SW2) cnt_r <= cnt_m1;
      if (ctl.op == imh_pkg::OP_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      imh_pkg::OP_IDLE: begin
        if (in_ch.valid) begin
          cmd_r     <= imh_pkg::cmd_t'(in_ch.command);
          in_key_r  <= in_ch.key;
          in_slot_r <= in_ch.slot;
        end
      end
      imh_pkg::OP_DISPATCH: begin
        status_r   <= imh_pkg::STS_OK;
        res_key_r  <= '0;
        res_slot_r <= '0;
        case (cmd_r)
          imh_pkg::CMD_INSERT:   if (sts.full) status_r <= imh_pkg::STS_FULL;
          imh_pkg::CMD_DECREASE: res_slot_r <= in_slot_r;
          default:               if (sts.empty) status_r <= imh_pkg::STS_EMPTY;
        endcase
      end
      imh_pkg::OP_INS_RD: begin
        s_r        <= sap_rd;
        p_r        <= cnt_r[PW-1:0];
        k_r        <= in_key_r;
        res_key_r  <= in_key_r;
        res_slot_r <= sap_rd;
      end
      imh_pkg::OP_UP_CHK:  op_r <= parent;
      imh_pkg::OP_UP_PAR:  o_r <= sap_rd;
      imh_pkg::OP_UP_SW2:  p_r <= op_r;
      imh_pkg::OP_DEC_CHK: begin
        if (sts.dec_bad) begin
          status_r <= imh_pkg::STS_DEC_REJ;
        end else begin
          s_r       <= in_slot_r;
          p_r       <= pos_rd;
          k_r       <= in_key_r;
          res_key_r <= in_key_r;
        end
      end
      imh_pkg::OP_PEEK_RD:  res_slot_r <= sap_rd;
      imh_pkg::OP_PEEK_KEY: res_key_r <= key_rd;
      imh_pkg::OP_EXT_RD0:  o_r <= sap_rd;
      imh_pkg::OP_EXT_RD1: begin
        s_r        <= sap_rd;
        res_key_r  <= key_rd;
        res_slot_r <= o_r;
      end
      imh_pkg::OP_EXT_SW1:  k_r <= key_rd;
      imh_pkg::OP_EXT_SW2:  p_r <= '0;
      imh_pkg::OP_DN_R: begin
        o_r  <= s_r;
        ok_r <= k_r;
        op_r <= p_r;
      end
      imh_pkg::OP_DN_RD_R, imh_pkg::OP_DN_RD_L: c_r <= sap_rd;
      imh_pkg::OP_DN_CMP_R: begin
        if (imh_pkg::key_leq(key_rd, ok_r, sgn_r)) begin
          o_r <= c_r; ok_r <= key_rd; op_r <= rkid[PW-1:0];
        end
      end
      imh_pkg::OP_DN_CMP_L: begin
        if (imh_pkg::key_leq(key_rd, ok_r, sgn_r)) begin
          o_r <= c_r; ok_r <= key_rd; op_r <= lkid[PW-1:0];
        end
      end
      imh_pkg::OP_DN_SW2: p_r <= op_r;
      imh_pkg::OP_DONE: begin
        if (out_free) begin
          out_status_r <= status_r;
          out_key_r    <= res_key_r;
          out_slot_r   <= res_slot_r;
          out_cnt_r    <= cnt_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready        = ctl.op == imh_pkg::OP_IDLE;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.result_key  = out_key_r;
  assign out_ch.result_slot = out_slot_r;
  assign out_ch.occupancy   = out_cnt_r;

  `IMH_ASSERT(a_cnt_bound, cnt_r <= CW'(imh_pkg::CAPACITY), "occupancy above capacity")
  `IMH_ASSERT_NEXT(a_ins_grow, ctl.op == imh_pkg::OP_INS_RD, cnt_r == $past(cnt_r) + CW'(1), "insert did not grow count")
  `IMH_ASSERT_NEXT(a_ext_shrink, ctl.op == imh_pkg::OP_EXT_SW2, cnt_r == $past(cnt_r) - CW'(1), "extract did not shrink count")
  `IMH_ASSERT(a_no_accept_busy, !(in_ch.valid && in_ch.ready) || ctl.op == imh_pkg::OP_IDLE, "beat taken while busy")
endmodule
